// ===== rtl/oilt_pkg.sv =====
// shared constants, codes and types of the ordered item list table
package oilt_pkg;

	localparam int DEPTH  = 16;
	localparam int ITEM_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int CMD_W  = 3;
	localparam int POS_W  = 5;
	localparam int VAL_W  = 32;
	localparam int CAP_W  = 5;
	localparam int PRES_W = 6;
	localparam int RMV_W  = 5;
	localparam int ICNT_W = 5;

	localparam int WIDE_W = (CNT_W > POS_W) ? ((CNT_W > CAP_W) ? CNT_W : CAP_W)
	                                        : ((POS_W > CAP_W) ? POS_W : CAP_W);

	localparam int IN_W        = CMD_W + POS_W + VAL_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 1 + PRES_W + RMV_W + VAL_W + ICNT_W + 1;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_INS_AT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_SORTED = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE_AT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WRITE_AT   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;

	localparam logic [PRES_W-1:0] NO_POS = '1;

	typedef logic [ITEM_W-1:0] item_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_CMP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp_le;
	} cell_ctl_t;

endpackage

// ===== rtl/ordered_item_list_table.sv =====
// top level of the ordered item list table: command sequencer over a row of list cells
//
//  channel   | dir | handshake                  | contents
//  s_axis    | in  | s_axis_tvalid/tready       | command, position, item_value
//  m_axis    | out | m_axis_tvalid/tready       | ok, position_result, removed_count,
//            |     |                            | read_value, item_count, is_empty
//  cfg       | in  | cfg_we                     | capacity
//
// a request passes a compare state that sets the match flags in every cell, then an execute state that shifts or writes
// remove_all_equal stays in the execute state while a match is left, one entry closed up per cycle
// the next request is taken in the cycle a request finishes; the result sits in an output register
// a stalled result holds the following request in its compare cycle
// reset empties the list and sets capacity to 16; cell contents are not cleared
module ordered_item_list_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// command[2:0], position[7:3], item_value[39:8]
	input  logic [oilt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// ok[0], position_result[6:1], removed_count[11:7], read_value[43:12],
	// item_count[48:44], is_empty[49], zero fill
	output logic [oilt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [oilt_pkg::CAP_W-1:0]       cfg_wdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	localparam int W = oilt_pkg::WIDE_W;

	logic [1:0]                     state_q;
	logic [oilt_pkg::CMD_W-1:0]     cmd_q;
	logic [oilt_pkg::POS_W-1:0]     pos_q;
	oilt_pkg::item_t                val_q;
	logic [oilt_pkg::CNT_W-1:0]     count_q;
	logic [oilt_pkg::CAP_W-1:0]     cap_q;
	logic [oilt_pkg::RMV_W-1:0]     removed_q;
	logic                           m_valid_q;
	logic [oilt_pkg::OUT_TDATA_W-1:0] m_data_q;

	oilt_pkg::cell_ctl_t            ctl   [oilt_pkg::DEPTH];
	oilt_pkg::item_t                entry [oilt_pkg::DEPTH];
	logic [oilt_pkg::DEPTH-1:0]     hit;
	logic [oilt_pkg::DEPTH-1:0]     hv;

	logic                           in_acc;
	logic                           out_free;
	logic                           exec_done;
	logic [W-1:0]                   cnt_w;
	logic [W-1:0]                   pos_w;
	logic [W-1:0]                   lim_w;
	logic                           found;
	logic [W-1:0]                   first_idx;
	oilt_pkg::item_t                rd_sel;

	logic                           ok_d;
	logic [oilt_pkg::PRES_W-1:0]    pres_d;
	oilt_pkg::item_t                rd_d;
	logic                           do_ins;
	logic [W-1:0]                   ins_at;
	logic                           do_del;
	logic [W-1:0]                   del_at;
	logic                           do_wr;
	logic [oilt_pkg::CNT_W-1:0]     count_d;
	logic [oilt_pkg::OUT_W-1:0]     out_d;

	assign out_free  = !m_valid_q || m_axis_tready;
	assign exec_done = !((cmd_q == oilt_pkg::CMD_REMOVE_ALL) && found);
	assign s_axis_tready = (state_q == S_IDLE) || ((state_q == S_EXEC) && exec_done);
	assign in_acc    = s_axis_tvalid && s_axis_tready;

	assign cnt_w = W'(count_q);
	assign pos_w = W'(pos_q);
	assign lim_w = (W'(cap_q) < W'(oilt_pkg::DEPTH)) ? W'(cap_q) : W'(oilt_pkg::DEPTH);

	// first flagged cell among the occupied ones, and the cell at position
	always_comb begin
		found     = 1'b0;
		first_idx = '0;
		rd_sel    = '0;
		for (int i = 0; i < oilt_pkg::DEPTH; i++) begin
			hv[i] = hit[i] && (W'(i) < cnt_w);
			if (W'(i) == pos_w) begin
				rd_sel = entry[i];
			end
		end
		for (int i = oilt_pkg::DEPTH - 1; i >= 0; i--) begin
			if (hv[i]) begin
				found     = 1'b1;
				first_idx = W'(i);
			end
		end
	end

	always_comb begin
		ok_d    = 1'b0;
		pres_d  = oilt_pkg::NO_POS;
		rd_d    = '0;
		do_ins  = 1'b0;
		ins_at  = '0;
		do_del  = 1'b0;
		del_at  = '0;
		do_wr   = 1'b0;
		count_d = count_q;
		case (cmd_q)
			oilt_pkg::CMD_INS_AT: begin
				if (pos_w <= cnt_w && cnt_w < lim_w) begin
					do_ins = 1'b1;
					ins_at = pos_w;
				end
			end
			oilt_pkg::CMD_INS_SORTED: begin
				if (cnt_w < lim_w) begin
					do_ins = 1'b1;
					ins_at = found ? first_idx : cnt_w;
				end
			end
			oilt_pkg::CMD_ERASE_AT: begin
				if (pos_w < cnt_w) begin
					ok_d   = 1'b1;
					do_del = 1'b1;
					del_at = pos_w;
				end
			end
			oilt_pkg::CMD_REMOVE_ALL: begin
				ok_d   = 1'b1;
				do_del = found;
				del_at = first_idx;
			end
			oilt_pkg::CMD_READ_AT: begin
				if (pos_w < cnt_w) begin
					ok_d = 1'b1;
					rd_d = rd_sel;
				end
			end
			oilt_pkg::CMD_WRITE_AT: begin
				if (pos_w < cnt_w) begin
					ok_d  = 1'b1;
					do_wr = 1'b1;
				end
			end
			oilt_pkg::CMD_FIND: begin
				ok_d = 1'b1;
				if (found) begin
					pres_d = oilt_pkg::PRES_W'(first_idx);
				end
			end
			default: ok_d = 1'b0;
		endcase
		if (do_ins) begin
			ok_d    = 1'b1;
			pres_d  = oilt_pkg::PRES_W'(ins_at);
			count_d = count_q + 1'b1;
		end
		if (do_del) begin
			count_d = count_q - 1'b1;
		end
	end

	// per-cell shift, load and compare controls
	always_comb begin
		for (int i = 0; i < oilt_pkg::DEPTH; i++) begin
			ctl[i].cmp_le = (cmd_q == oilt_pkg::CMD_INS_SORTED);
			ctl[i].op     = oilt_pkg::CELL_HOLD;
			if (state_q == S_CMP) begin
				ctl[i].op = oilt_pkg::CELL_CMP;
			end else if (state_q == S_EXEC) begin
				if (do_ins && W'(i) > ins_at) begin
					ctl[i].op = oilt_pkg::CELL_LEFT;
				end else if (do_ins && W'(i) == ins_at) begin
					ctl[i].op = oilt_pkg::CELL_LOAD;
				end else if (do_del && W'(i) >= del_at) begin
					ctl[i].op = oilt_pkg::CELL_RIGHT;
				end else if (do_wr && W'(i) == pos_w) begin
					ctl[i].op = oilt_pkg::CELL_LOAD;
				end
			end
		end
	end

	for (genvar g = 0; g < oilt_pkg::DEPTH; g++) begin : g_cell
		oilt_pkg::item_t left_e;
		oilt_pkg::item_t right_e;
		logic            left_h;
		logic            right_h;
		if (g == 0) begin : g_first
			assign left_e = '0;
			assign left_h = 1'b0;
		end else begin : g_mid_l
			assign left_e = entry[g-1];
			assign left_h = hit[g-1];
		end
		if (g == oilt_pkg::DEPTH - 1) begin : g_last
			assign right_e = '0;
			assign right_h = 1'b0;
		end else begin : g_mid_r
			assign right_e = entry[g+1];
			assign right_h = hit[g+1];
		end
		oilt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[g]),
			.load_value  (val_q),
			.left_entry  (left_e),
			.left_hit    (left_h),
			.right_entry (right_e),
			.right_hit   (right_h),
			.entry       (entry[g]),
			.hit         (hit[g])
		);
	end

	assign out_d = {(count_d == '0), oilt_pkg::ICNT_W'(count_d), oilt_pkg::VAL_W'(rd_d),
	                removed_q, pres_d, ok_d};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= s_axis_tdata[oilt_pkg::CMD_W-1:0];
			pos_q <= s_axis_tdata[oilt_pkg::CMD_W +: oilt_pkg::POS_W];
			val_q <= s_axis_tdata[oilt_pkg::CMD_W + oilt_pkg::POS_W +: oilt_pkg::ITEM_W];
		end
		if (state_q == S_EXEC && exec_done) begin
			m_data_q <= oilt_pkg::OUT_TDATA_W'(out_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cap_q     <= oilt_pkg::CAP_W'(16);
			removed_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (out_free) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q <= count_d;
					if (!exec_done) begin
						removed_q <= removed_q + 1'b1;
					end else begin
						m_valid_q <= 1'b1;
						state_q   <= in_acc ? S_CMP : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (in_acc) begin
				removed_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= oilt_pkg::CNT_W'(oilt_pkg::DEPTH))
		else $error("item count above depth");

	a_exec_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !m_valid_q)
		else $error("execute cycle with result register occupied");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result raised outside execute cycle");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == S_CMP))
		else $error("accepted request did not enter compare");

endmodule

// ===== rtl/oilt_cell.sv =====
// one list slot: holds an item and its match flag, shifts to either neighbor
module oilt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  oilt_pkg::cell_ctl_t ctl,
	input  oilt_pkg::item_t    load_value,
	input  oilt_pkg::item_t    left_entry,
	input  logic               left_hit,
	input  oilt_pkg::item_t    right_entry,
	input  logic               right_hit,
	output oilt_pkg::item_t    entry,
	output logic               hit
);

	oilt_pkg::item_t entry_q;
	logic            hit_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			oilt_pkg::CELL_LOAD:  entry_q <= load_value;
			oilt_pkg::CELL_LEFT:  entry_q <= left_entry;
			oilt_pkg::CELL_RIGHT: entry_q <= right_entry;
			default:              entry_q <= entry_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			case (ctl.op)
				oilt_pkg::CELL_CMP: begin
					hit_q <= ctl.cmp_le ? (load_value <= entry_q) : (load_value == entry_q);
				end
				oilt_pkg::CELL_LOAD:  hit_q <= 1'b0;
				oilt_pkg::CELL_LEFT:  hit_q <= left_hit;
				oilt_pkg::CELL_RIGHT: hit_q <= right_hit;
				default:              hit_q <= hit_q;
			endcase
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule
